### design/fpa_pkg.sv
// Package: opcodes, request/response words and shared helpers for the fixed-point ALU.
`default_nettype none
package fpa_pkg;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_TO_INT   = 4'd14,
      OP_FROM_INT = 4'd15
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               compare_true;
      logic               overflowed;
      logic               divided_by_zero;
   } rsp_type;

   // per-word control travelling alongside the divider chain
   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [31:0] result;
      logic        cmp;
      logic        ovf;
      logic        dz;
      logic        neg;
   } meta_type;

   typedef struct packed {
      logic [31:0] value;
      logic        ovf;
   } sat_type;

   // sign a magnitude and clamp it to an ew-bit signed range
   function automatic sat_type sat_mag(input logic [63:0] mag, input logic neg, input int ew);
      logic [63:0] limit;
      sat_type     r;
      limit = 64'd1 << (ew - 1);
      r.ovf = 1'b0;
      if (neg) begin
         if (mag > limit) begin
            r.ovf   = 1'b1;
            r.value = 32'(64'd0 - limit);
         end else begin
            r.value = 32'(64'd0 - mag);
         end
      end else begin
         if (mag > limit - 64'd1) begin
            r.ovf   = 1'b1;
            r.value = 32'(limit - 64'd1);
         end else begin
            r.value = 32'(mag);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### design/fixed_point_alu.sv
// Top level: signed fixed-point ALU with a pipelined divider chain.
//
//   channel  | ports                      | handshake
//   request  | start, busy, req_word      | taken when start & !busy
//   response | rsp_strobe, rsp_word       | one-cycle strobe, no backpressure
//
// One word may enter every cycle; busy is always low.
// Every op takes the same path through the front end, the divider chain and the back end
// (EW = WORD_WIDTH clipped to 8..32); the chain has EW + FB + 2 cells, one quotient bit per cell.
// Synchronous reset clears the valid bits of the pipeline; no words are in flight afterward.
// The receiver cannot stall; results appear in request order.
`default_nettype none
module fixed_point_alu #(
   parameter int FRAC_BITS  = 8,
   parameter int WORD_WIDTH = 32
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  fpa_pkg::req_type req_word,
   output logic             rsp_strobe,
   output fpa_pkg::rsp_type rsp_word
);
   import fpa_pkg::*;

   localparam int EW = WORD_WIDTH > 32 ? 32 : (WORD_WIDTH < 8 ? 8 : WORD_WIDTH);
   localparam int FB = FRAC_BITS;
   localparam int NW = EW + FB + 2;

   meta_type      meta_c [NW+1];
   logic [NW-1:0] num_c  [NW+1];
   logic [EW:0]   den_c  [NW+1];
   logic [EW:0]   rem_c  [NW+1];
   logic [NW-1:0] quo_c  [NW+1];

   assign busy     = 1'b0;
   assign rem_c[0] = '0;
   assign quo_c[0] = '0;

   fpa_front #(.EW(EW), .FB(FB)) u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (start & ~busy),
      .req_word (req_word),
      .meta_out (meta_c[0]),
      .num_out  (num_c[0]),
      .den_out  (den_c[0])
   );

   for (genvar i = 0; i < NW; i++) begin : g_cell
      fpa_div_cell #(.EW(EW), .FB(FB)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .meta_in  (meta_c[i]),
         .num_in   (num_c[i]),
         .den_in   (den_c[i]),
         .rem_in   (rem_c[i]),
         .quo_in   (quo_c[i]),
         .meta_out (meta_c[i+1]),
         .num_out  (num_c[i+1]),
         .den_out  (den_c[i+1]),
         .rem_out  (rem_c[i+1]),
         .quo_out  (quo_c[i+1])
      );
   end

   fpa_back #(.EW(EW), .FB(FB)) u_back (
      .clock      (clock),
      .reset      (reset),
      .meta_in    (meta_c[NW]),
      .quo_in     (quo_c[NW]),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );
endmodule
`default_nettype wire

### design/fpa_front.sv
// Front end: operand decode, simple ops, multiplier and divider setup (two stages).
`default_nettype none
module fpa_front #(
   parameter int EW = 32,
   parameter int FB = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              take,
   input  fpa_pkg::req_type req_word,
   output fpa_pkg::meta_type meta_out,
   output logic [EW+FB+1:0] num_out,
   output logic [EW:0]      den_out
);
   import fpa_pkg::*;

   localparam int NW = EW + FB + 2;
   localparam logic signed [33:0] WMAX_X = 34'((64'd1 << (EW - 1)) - 64'd1);
   localparam logic signed [33:0] WMIN_X = -WMAX_X - 34'sd1;
   localparam logic [63:0] HALF = 64'd1 << (FB - 1);

   logic signed [EW-1:0] a_w, b_w;
   logic signed [33:0]   a_x, b_x, sum_x;
   logic [EW-1:0]        ma_w, mb_w;
   logic                 a_neg, b_neg;
   meta_type             meta1_in, meta1_ff, meta2_in, meta2_ff;
   logic [2*EW-1:0]      prod_in, prod_ff;
   logic [NW-1:0]        num1_in, num1_ff, num2_ff;
   logic [EW:0]          den1_in, den1_ff, den2_ff;
   sat_type              sat_v;

   always_comb begin
      a_w   = req_word.operand_a[EW-1:0];
      b_w   = req_word.operand_b[EW-1:0];
      a_x   = 34'(a_w);
      b_x   = 34'(b_w);
      a_neg = a_x < 0;
      b_neg = b_x < 0;
      ma_w  = EW'(a_neg ? -a_x : a_x);
      mb_w  = EW'(b_neg ? -b_x : b_x);
      prod_in = (2*EW)'(ma_w) * (2*EW)'(mb_w);
      num1_in = (NW'(ma_w) << (FB + 1)) + NW'(mb_w);
      den1_in = {mb_w, 1'b0};
      sum_x   = '0;
      sat_v   = '0;
      meta1_in       = '0;
      meta1_in.valid = take;
      meta1_in.kind  = req_word.kind;
      meta1_in.neg   = a_neg ^ b_neg;
      meta1_in.dz    = (mb_w == '0);
      case (req_word.kind)
         OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
            case (req_word.kind)
               OP_ADD:  sum_x = a_x + b_x;
               OP_SUB:  sum_x = a_x - b_x;
               OP_INC:  sum_x = a_x + 34'sd1;
               default: sum_x = a_x - 34'sd1;
            endcase
            if (sum_x > WMAX_X) begin
               meta1_in.result = 32'(WMAX_X);
               meta1_in.ovf    = 1'b1;
            end else if (sum_x < WMIN_X) begin
               meta1_in.result = 32'(WMIN_X);
               meta1_in.ovf    = 1'b1;
            end else begin
               meta1_in.result = 32'(sum_x);
            end
         end
         OP_GT:  meta1_in.cmp = a_x > b_x;
         OP_LT:  meta1_in.cmp = a_x < b_x;
         OP_GE:  meta1_in.cmp = a_x >= b_x;
         OP_LE:  meta1_in.cmp = a_x <= b_x;
         OP_EQ:  meta1_in.cmp = a_x == b_x;
         OP_NE:  meta1_in.cmp = a_x != b_x;
         OP_MIN: meta1_in.result = 32'(a_x <= b_x ? a_x : b_x);
         OP_MAX: meta1_in.result = 32'(a_x >= b_x ? a_x : b_x);
         OP_TO_INT: begin
            sat_v = sat_mag(64'(ma_w >> FB), a_neg, EW);
            meta1_in.result = sat_v.value;
         end
         OP_FROM_INT: begin
            sat_v = sat_mag(64'(ma_w) << FB, a_neg, EW);
            meta1_in.result = sat_v.value;
            meta1_in.ovf    = sat_v.ovf;
         end
         default: ;
      endcase
   end

   // stage 2: round and clamp the product
   logic [63:0] prod_rnd;
   sat_type     sat_m;
   always_comb begin
      prod_rnd = (64'(prod_ff) + HALF) >> FB;
      sat_m    = sat_mag(prod_rnd, meta1_ff.neg, EW);
      meta2_in = meta1_ff;
      if (meta1_ff.kind == OP_MUL) begin
         meta2_in.result = sat_m.value;
         meta2_in.ovf    = sat_m.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta1_ff <= '0;
         meta2_ff <= '0;
      end else begin
         meta1_ff <= meta1_in;
         meta2_ff <= meta2_in;
      end
      prod_ff <= prod_in;
      num1_ff <= num1_in;
      den1_ff <= den1_in;
      num2_ff <= num1_ff;
      den2_ff <= den1_ff;
   end

   assign meta_out = meta2_ff;
   assign num_out  = num2_ff;
   assign den_out  = den2_ff;
endmodule
`default_nettype wire

### design/fpa_div_cell.sv
// Divider cell: one restoring quotient bit per cycle, passes the word to its neighbor.
`default_nettype none
module fpa_div_cell #(
   parameter int EW = 32,
   parameter int FB = 8
) (
   input  wire                clock,
   input  wire                reset,
   input  fpa_pkg::meta_type  meta_in,
   input  wire [EW+FB+1:0]    num_in,
   input  wire [EW:0]         den_in,
   input  wire [EW:0]         rem_in,
   input  wire [EW+FB+1:0]    quo_in,
   output fpa_pkg::meta_type  meta_out,
   output logic [EW+FB+1:0]   num_out,
   output logic [EW:0]        den_out,
   output logic [EW:0]        rem_out,
   output logic [EW+FB+1:0]   quo_out
);
   import fpa_pkg::*;

   localparam int NW = EW + FB + 2;

   meta_type      meta_ff;
   logic [NW-1:0] num_ff, quo_ff, quo_in_w;
   logic [EW:0]   den_ff, rem_ff, rem_in_w;
   logic [EW+1:0] trial;
   logic          fits;

   always_comb begin
      trial    = {rem_in, num_in[NW-1]};
      fits     = trial >= {1'b0, den_in};
      rem_in_w = fits ? (EW+1)'(trial - {1'b0, den_in}) : trial[EW:0];
      quo_in_w = {quo_in[NW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff <= '0;
      end else begin
         meta_ff <= meta_in;
      end
      num_ff <= num_in << 1;
      den_ff <= den_in;
      rem_ff <= rem_in_w;
      quo_ff <= quo_in_w;
   end

   assign meta_out = meta_ff;
   assign num_out  = num_ff;
   assign den_out  = den_ff;
   assign rem_out  = rem_ff;
   assign quo_out  = quo_ff;
endmodule
`default_nettype wire

### design/fpa_back.sv
// Back end: quotient sign and clamp, result register and strobe.
`default_nettype none
module fpa_back #(
   parameter int EW = 32,
   parameter int FB = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  fpa_pkg::meta_type meta_in,
   input  wire [EW+FB+1:0]   quo_in,
   output logic              rsp_strobe,
   output fpa_pkg::rsp_type  rsp_word
);
   import fpa_pkg::*;

   rsp_type rsp_in, rsp_ff;
   logic    strobe_ff;
   sat_type sat_q;

   always_comb begin
      sat_q = sat_mag(64'(quo_in), meta_in.neg, EW);
      rsp_in.result_value    = meta_in.result;
      rsp_in.compare_true    = meta_in.cmp;
      rsp_in.overflowed      = meta_in.ovf;
      rsp_in.divided_by_zero = 1'b0;
      if (meta_in.kind == OP_DIV) begin
         if (meta_in.dz) begin
            rsp_in.result_value    = '0;
            rsp_in.overflowed      = 1'b0;
            rsp_in.divided_by_zero = 1'b1;
         end else begin
            rsp_in.result_value = sat_q.value;
            rsp_in.overflowed   = sat_q.ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= meta_in.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;
endmodule
`default_nettype wire

### dv/fixed_point_alu_tb.sv
// Testbench for the fixed-point ALU: directed and random words checked against a local predictor.
`timescale 1ns / 100ps
`default_nettype none
module fixed_point_alu_tb;
   import fpa_pkg::*;

   localparam int FRAC_BITS  = 8;
   localparam int WORD_WIDTH = 32;
   localparam int EW = (WORD_WIDTH < 8) ? 8 : ((WORD_WIDTH > 32) ? 32 : WORD_WIDTH);
   localparam int FB = FRAC_BITS;
   localparam int LATENCY = EW + FB + 5;
   localparam int WATCHDOG_LIMIT = 50 * LATENCY + 2000;
   localparam longint WMAX = (64'sd1 <<< (EW - 1)) - 1;
   localparam longint WMIN = -WMAX - 1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   fixed_point_alu #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      words_sent = 0;
   int      words_checked = 0;
   int      idle_pct = 0;
   int      stall_cycles = 0;

   function automatic longint sext_word(logic [31:0] raw);
      logic [63:0] low;
      low = 64'(raw) & ((64'd1 << EW) - 1);
      if (low[EW-1]) return longint'(low) - (64'sd1 <<< EW);
      return longint'(low);
   endfunction

   function automatic longint clamp(longint v, inout logic ovf);
      if (v > WMAX) begin ovf = 1'b1; return WMAX; end
      if (v < WMIN) begin ovf = 1'b1; return WMIN; end
      return v;
   endfunction

   function automatic rsp_type alu_predict(req_type rq);
      longint a, b, r;
      logic [63:0] ma, mb, p, q;
      logic neg, cmp, ovf, dz;
      rsp_type rs;
      a = sext_word(rq.operand_a);
      b = sext_word(rq.operand_b);
      ma = (a < 0) ? 64'(-a) : 64'(a);
      mb = (b < 0) ? 64'(-b) : 64'(b);
      neg = (a < 0) != (b < 0);
      r = 0; cmp = 0; ovf = 0; dz = 0;
      case (rq.kind)
         OP_ADD: r = clamp(a + b, ovf);
         OP_SUB: r = clamp(a - b, ovf);
         OP_MUL: begin
            p = (ma * mb + (64'd1 << (FB - 1))) >> FB;
            r = clamp(neg ? -longint'(p) : longint'(p), ovf);
         end
         OP_DIV: begin
            if (mb == 0) dz = 1'b1;
            else begin
               q = (((ma << FB) * 2) + mb) / (mb * 2);
               r = clamp(neg ? -longint'(q) : longint'(q), ovf);
            end
         end
         OP_GT: cmp = a > b;
         OP_LT: cmp = a < b;
         OP_GE: cmp = a >= b;
         OP_LE: cmp = a <= b;
         OP_EQ: cmp = a == b;
         OP_NE: cmp = a != b;
         OP_MIN: r = (a <= b) ? a : b;
         OP_MAX: r = (a >= b) ? a : b;
         OP_INC: r = clamp(a + 1, ovf);
         OP_DEC: r = clamp(a - 1, ovf);
         OP_TO_INT: r = (a < 0) ? -longint'(ma >> FB) : longint'(ma >> FB);
         default: r = clamp((a < 0) ? -longint'(ma << FB) : longint'(ma << FB), ovf);
      endcase
      rs.result_value = r[31:0];
      rs.compare_true = cmp;
      rs.overflowed = ovf;
      rs.divided_by_zero = dz;
      return rs;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         stall_cycles <= 0;
         words_checked <= words_checked + 1;
         if (expected_rsps.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected response word %h", rsp_word);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_word !== exp_rsp) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected val=%h cmp=%b ovf=%b dz=%b, got val=%h cmp=%b ovf=%b dz=%b",
                     exp_rsp.result_value, exp_rsp.compare_true, exp_rsp.overflowed,
                     exp_rsp.divided_by_zero, rsp_word.result_value, rsp_word.compare_true,
                     rsp_word.overflowed, rsp_word.divided_by_zero);
            end
         end
      end else if (!(start && !busy)) begin
         stall_cycles <= stall_cycles + 1;
      end else begin
         stall_cycles <= 0;
      end
   end

   always @(posedge clock) begin
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", stall_cycles);
         $display("fixed_point_alu_tb: errors");
         $finish;
      end
   end

   // start stays high across back-to-back words; it drops only while idling or draining
   task automatic send_word(kind_type kind, logic [31:0] a, logic [31:0] b);
      req_type rq;
      rq.kind = kind; rq.operand_a = a; rq.operand_b = b;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsps.push_back(alu_predict(rq));
      words_sent++;
   endtask

   task automatic drain;
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0: return 32'h7fffffff - $urandom_range(3);
         1: return 32'h80000000 + $urandom_range(3);
         2: return $urandom_range(1023) - 512;
         3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
         4: return ($urandom_range(1)) ? 32'(FB == 0 ? 0 : (1 << FB)) : -32'(1 << FB);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed;
      logic [31:0] ext[6];
      ext = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h100};
      for (int k = 0; k < 16; k++) send_word(kind_type'(k), ext[k % 6], ext[(k + 3) % 6]);
      send_word(OP_DIV, 32'h500, 32'h0);
      send_word(OP_INC, 32'h7fffffff, 32'h0);
      send_word(OP_DEC, 32'h80000000, 32'h0);
      send_word(OP_TO_INT, 32'hfffffe80, 32'h0);
      send_word(OP_FROM_INT, 32'h00800000, 32'h0);
      send_word(OP_MIN, 32'h123, 32'h123);
      send_word(OP_MUL, 32'h80000000, 32'h80000000);
      send_word(OP_DIV, 32'h80000000, 32'h1);
      drain();
   endtask

   task automatic test_random(int count, int pct);
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(15) == 0) send_word(OP_DIV, rand_operand(), 32'h0);
         else send_word(kind_type'($urandom_range(15)), rand_operand(), rand_operand());
      end
      idle_pct = 0;
   endtask

   task automatic test_pause_until_empty;
      send_word(OP_ADD, $urandom, $urandom);
      drain();
      send_word(OP_SUB, $urandom, $urandom);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(630, 15);
      test_pause_until_empty();
      test_random(630, 51);
      test_random(630, 0);
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d words over all sixteen opcodes, extremes and zero divisors", words_sent);
      $display("checked %0d responses under three idle patterns", words_checked);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("fixed_point_alu_tb: clean");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, expected_rsps.size());
         $display("fixed_point_alu_tb: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
design/fpa_pkg.sv
design/fpa_front.sv
design/fpa_div_cell.sv
design/fpa_back.sv
design/fixed_point_alu.sv
dv/fixed_point_alu_tb.sv
